FILE: rtl/mot_pkg.sv
// ----------------------------------------------------------------------------
// mot_pkg
// Shared types and constants for the multiplicative order of two unit:
// controller to datapath command and status words.
// ----------------------------------------------------------------------------
package mot_pkg;

	// width of the order field on the result port
	localparam int ORDER_W = 16;

	// width of the modulus field on the input port
	localparam int MODULUS_W = 16;

	// commands from the controller to the datapath
	typedef struct packed {
		logic start;     // capture modulus, set power to one, clear count
		logic step;      // double and reduce the power, bump the count
		logic load_out;  // move the answer into the output register
	} mot_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic last;      // current step ends the search
	} mot_sts_t;

	// controller states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} mot_state_t;

endpackage

FILE: rtl/multiplicative_order_of_two_unit.sv
// out_valid rises once the search steps have ended and the answer is loaded
//   into the output register, also for n of zero, one or even n.
// A new word is taken only after the previous search has ended and its answer
//   is loaded; the search does a single doubling and reduce step per cycle.
// A finished word waits in the output register while the next is taken.
// Reset (arst_n low) clears the controller and the result valid flag.
// ----------------------------------------------------------------------------
// multiplicative_order_of_two_unit
// Finds the least x > 0 with 2^x mod n equal to one by stepping powers of
// two modulo n; reports found = 0 and order = 0 when no such x exists.
// ----------------------------------------------------------------------------
module multiplicative_order_of_two_unit #(
	parameter int MOD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mot_pkg::MODULUS_W-1:0] modulus,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [mot_pkg::ORDER_W-1:0]   order
);

	mot_pkg::mot_cmd_t cmd;
	mot_pkg::mot_sts_t sts;

	// sequencer
	mot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// search datapath and output register
	mot_dpath #(
		.MOD_WIDTH (MOD_WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.modulus (modulus),
		.found   (found),
		.order   (order)
	);

endmodule

FILE: rtl/mot_dpath.sv
// ----------------------------------------------------------------------------
// mot_dpath
// Datapath: holds the modulus, the running power of two modulo n and the
// exponent count; one doubling with a single conditional subtract per step.
// ----------------------------------------------------------------------------
module mot_dpath #(
	parameter int MOD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mot_pkg::mot_cmd_t                 cmd,
	output mot_pkg::mot_sts_t                 sts,
	input  logic [mot_pkg::MODULUS_W-1:0]     modulus,
	output logic                              found,
	output logic [mot_pkg::ORDER_W-1:0]       order
);

	localparam int XW = (MOD_WIDTH > mot_pkg::ORDER_W) ? MOD_WIDTH : mot_pkg::ORDER_W;

	logic [MOD_WIDTH-1:0] n_q;
	logic [MOD_WIDTH-1:0] v_q;
	logic [MOD_WIDTH-1:0] x_q;
	logic                 nvalid_q;
	logic                 found_q;
	logic [mot_pkg::ORDER_W-1:0] order_q;

	logic [MOD_WIDTH-1:0] n_in;
	logic [MOD_WIDTH:0]   v_dbl;
	logic [MOD_WIDTH-1:0] v_nx;
	logic [MOD_WIDTH-1:0] x_nx;
	logic [XW-1:0]        x_ext;

	// low MOD_WIDTH bits of the incoming word
	assign n_in = MOD_WIDTH'(modulus);

	// doubling step, v < n so one subtract reduces it
	always_comb begin
		v_dbl = {v_q, 1'b0};
		if (v_dbl >= {1'b0, n_q}) begin
			v_nx = MOD_WIDTH'(v_dbl - {1'b0, n_q});
		end else begin
			v_nx = v_dbl[MOD_WIDTH-1:0];
		end
		x_nx = x_q + MOD_WIDTH'(1);
	end

	// search ends when n has no order, the power is back at one or the count reaches n
	assign sts.last = !nvalid_q || (v_nx == MOD_WIDTH'(1)) || (x_nx >= n_q);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q      <= n_in;
			nvalid_q <= n_in[0] && (n_in != MOD_WIDTH'(1));
			v_q      <= MOD_WIDTH'(1);
			x_q      <= '0;
		end else if (cmd.step) begin
			v_q <= v_nx;
			x_q <= x_nx;
		end
	end

	// output register
	assign x_ext = XW'(x_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found_q <= nvalid_q;
			order_q <= nvalid_q ? x_ext[mot_pkg::ORDER_W-1:0] : '0;
		end
	end

	assign found = found_q;
	assign order = order_q;

	// power stays nonzero and below n during a valid search
	a_pow_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && nvalid_q) |-> (v_q != '0) && (v_q < n_q))
		else $error("power out of range");

	// count never passes the modulus while stepping
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && nvalid_q) |-> (x_q < n_q))
		else $error("exponent count beyond modulus");

endmodule

FILE: rtl/mot_ctrl.sv
// ----------------------------------------------------------------------------
// mot_ctrl
// Controller: accepts a word, sequences the search steps and hands the
// answer to the output register when the result slot is free.
// ----------------------------------------------------------------------------
module mot_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mot_pkg::mot_cmd_t  cmd,
	input  mot_pkg::mot_sts_t  sts
);

	mot_pkg::mot_state_t state_q;
	mot_pkg::mot_state_t state_nx;
	logic                out_valid_q;
	logic                slot_free;

	// output slot can take a new word this cycle
	assign slot_free = !out_valid_q || out_ready;

	assign in_ready  = (state_q == mot_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nx     = state_q;
		cmd.start    = 1'b0;
		cmd.step     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			mot_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nx  = mot_pkg::ST_RUN;
				end
			end
			mot_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_nx = mot_pkg::ST_FIN;
				end
			end
			mot_pkg::ST_FIN: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_nx     = mot_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = mot_pkg::ST_IDLE;
			end
		endcase
	end

	// state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mot_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a pending result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.load_out)
		else $error("result overwritten while pending");

	// every accepted word leads to a search step next cycle
	a_start_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> cmd.step)
		else $error("search did not start after accept");

	// a load always raises the result valid flag
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result valid missing after load");

	// only one command at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.step, cmd.load_out}))
		else $error("overlapping commands");

endmodule
